@@ sv/advys_pkg.sv @@
// Package with the item types and fixed constants of the y-advection stencil point.
package advys_pkg;

  localparam int FIELD_W = 32;
  localparam int DIV_STEPS = 33;   // quotient bits below the 2^33 hold level

  typedef struct packed {
    logic [31:0] hx_face;
    logic [31:0] hx_left;
    logic [31:0] hx_right;
    logic [31:0] hy_center;
    logic [31:0] uy_low_left;
    logic [31:0] uy_low_right;
    logic [31:0] uy_high_left;
    logic [31:0] uy_high_right;
    logic [31:0] ux_below;
    logic [31:0] ux_here;
    logic [31:0] ux_above;
    logic [31:0] incr_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] incr_out;
    logic        saturated;
  } out_item_t;

endpackage

@@ sv/advection_y_stencil_point.sv @@
// Pipelined y-direction advection update of one x-velocity increment.
//
// One item is accepted every clock cycle unless the output stalls, and passes
// seven arithmetic stages (products, rounding, flux, dt scaling, range check),
// a 33-stage restoring divider that retires one quotient bit per stage for the
// division by hx_face*hy_center, and the output register. A stall on the result
// side freezes the whole pipeline; nothing is dropped or repeated. Velocities are
// Q16.16 in the low DATA_WIDTH bits (16..32, other values act as the nearest
// limit), scale factors are unsigned Q8.24, and any clamp raises saturated.
// time_step is written through the cfg port, which is always ready.
module advection_y_stencil_point #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  advys_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output advys_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);

  localparam int W = (DATA_WIDTH < 16) ? 16 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
  localparam int NS = advys_pkg::DIV_STEPS;
  localparam logic signed [63:0] MAX_V = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] MIN_V = -MAX_V - 64'sd1;

  typedef struct packed {
    logic [63:0] r;
    logic [63:0] jac;
    logic [32:0] q;
    logic        b0;
    logic        zero;
    logic        cap;
    logic        neg;
    logic        sat;
    logic [31:0] inc;
  } div_t;

  // Returns {clamped flag, value sign-extended to 32 bits}.
  function automatic logic [32:0] clamp_w(input logic signed [63:0] x);
    logic [32:0] res;
    if (x > MAX_V) begin
      res = {1'b1, MAX_V[31:0]};
    end else if (x < MIN_V) begin
      res = {1'b1, MIN_V[31:0]};
    end else begin
      res = {1'b0, x[31:0]};
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sx(input logic [31:0] v);
    logic signed [W-1:0] t;
    t = $signed(v[W-1:0]);
    return 32'(t);
  endfunction

  logic        adv;
  logic [31:0] time_step_r;

  // Stage 1
  logic               s1_v_r;
  logic signed [64:0] s1_p0_r, s1_p1_r, s1_p2_r, s1_p3_r;
  logic signed [31:0] s1_dm_r, s1_dp_r, s1_inc_r;
  logic [63:0]        s1_jac_r;
  logic               s1_sat_r;
  // Stage 2
  logic               s2_v_r;
  logic signed [31:0] s2_va_r, s2_vb_r, s2_dm_r, s2_dp_r, s2_inc_r;
  logic [63:0]        s2_jac_r;
  logic               s2_sat_r;
  // Stage 3
  logic               s3_v_r;
  logic signed [63:0] s3_f0_r, s3_f1_r;
  logic signed [31:0] s3_inc_r;
  logic [63:0]        s3_jac_r;
  logic               s3_sat_r;
  // Stage 4
  logic               s4_v_r;
  logic [46:0]        s4_mag_r;
  logic               s4_neg_r;
  logic signed [31:0] s4_inc_r;
  logic [63:0]        s4_jac_r;
  logic               s4_sat_r;
  // Stage 5
  logic               s5_v_r;
  logic [63:0]        s5_pl_r;
  logic [46:0]        s5_ph_r;
  logic               s5_neg_r;
  logic signed [31:0] s5_inc_r;
  logic [63:0]        s5_jac_r;
  logic               s5_sat_r;
  // Stage 6
  logic               s6_v_r;
  logic [78:0]        s6_p_r;
  logic               s6_neg_r;
  logic signed [31:0] s6_inc_r;
  logic [63:0]        s6_jac_r;
  logic               s6_sat_r;
  // Divider
  logic [NS:0]        dv_v_r;
  div_t               dv_r [NS+1];
  div_t               dv_nxt [NS+1];
  // Output
  logic               out_valid_r;
  advys_pkg::out_item_t out_data_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      time_step_r <= cfg_data;
    end
  end

  // Stage combinational logic
  logic signed [32:0] hl_s, hr_s;
  logic signed [32:0] dm_w, dp_w;
  logic [32:0]        dm_c, dp_c;
  logic signed [41:0] sa_w, sb_w;
  logic [32:0]        va_c, vb_c;
  logic signed [46:0] flux_w;
  logic [79:0]        p_nxt;
  logic signed [35:0] res_w;
  logic [33:0]        q_fin;
  logic [32:0]        res_c;

  always_comb begin
    hl_s = $signed({1'b0, in_data.hx_left});
    hr_s = $signed({1'b0, in_data.hx_right});
    dm_w = 33'(sx(in_data.ux_here)) - 33'(sx(in_data.ux_below));
    dp_w = 33'(sx(in_data.ux_above)) - 33'(sx(in_data.ux_here));
    dm_c = clamp_w(64'(dm_w));
    dp_c = clamp_w(64'(dp_w));

    sa_w = 42'((s1_p0_r + 65'sd8388608) >>> 24) + 42'((s1_p1_r + 65'sd8388608) >>> 24);
    sb_w = 42'((s1_p2_r + 65'sd8388608) >>> 24) + 42'((s1_p3_r + 65'sd8388608) >>> 24);
    va_c = clamp_w(64'(sa_w));
    vb_c = clamp_w(64'(sb_w));

    flux_w = 47'((s3_f0_r + 64'sd131072) >>> 18) + 47'((s3_f1_r + 64'sd131072) >>> 18);

    p_nxt = {16'd0, s5_pl_r} + {1'b0, s5_ph_r, 32'd0};

    if (dv_r[NS].zero) begin
      q_fin = 34'd0;
    end else if (dv_r[NS].cap) begin
      q_fin = 34'h2_0000_0000;
    end else begin
      q_fin = {1'b0, dv_r[NS].q};
    end
    if (dv_r[NS].neg) begin
      res_w = 36'($signed(dv_r[NS].inc)) + $signed({2'b00, q_fin});
    end else begin
      res_w = 36'($signed(dv_r[NS].inc)) - $signed({2'b00, q_fin});
    end
    res_c = clamp_w(64'(res_w));
  end

  // One restoring division step per stage; only the first step can shift in a nonzero bit.
  always_comb begin
    logic [64:0] rs;
    logic        ge;
    for (int k = 0; k <= NS; k++) begin
      dv_nxt[k] = dv_r[k];
    end
    for (int k = 0; k < NS; k++) begin
      rs = {dv_r[k].r, (k == 0) ? dv_r[k].b0 : 1'b0};
      ge = rs >= {1'b0, dv_r[k].jac};
      dv_nxt[k+1]   = dv_r[k];
      dv_nxt[k+1].r = ge ? 64'(rs - {1'b0, dv_r[k].jac}) : rs[63:0];
      dv_nxt[k+1].q = {dv_r[k].q[31:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      dv_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      dv_v_r      <= {dv_v_r[NS-1:0], s6_v_r};
      out_valid_r <= dv_v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p0_r  <= hl_s * sx(in_data.uy_low_left);
      s1_p1_r  <= hr_s * sx(in_data.uy_low_right);
      s1_p2_r  <= hl_s * sx(in_data.uy_high_left);
      s1_p3_r  <= hr_s * sx(in_data.uy_high_right);
      s1_dm_r  <= dm_c[31:0];
      s1_dp_r  <= dp_c[31:0];
      s1_sat_r <= dm_c[32] | dp_c[32];
      s1_inc_r <= sx(in_data.incr_in);
      s1_jac_r <= in_data.hx_face * in_data.hy_center;

      s2_va_r  <= va_c[31:0];
      s2_vb_r  <= vb_c[31:0];
      s2_dm_r  <= s1_dm_r;
      s2_dp_r  <= s1_dp_r;
      s2_sat_r <= s1_sat_r | va_c[32] | vb_c[32];
      s2_inc_r <= s1_inc_r;
      s2_jac_r <= s1_jac_r;

      s3_f0_r  <= s2_va_r * s2_dm_r;
      s3_f1_r  <= s2_vb_r * s2_dp_r;
      s3_sat_r <= s2_sat_r;
      s3_inc_r <= s2_inc_r;
      s3_jac_r <= s2_jac_r;

      s4_mag_r <= flux_w[46] ? 47'(-flux_w) : flux_w;
      s4_neg_r <= flux_w[46];
      s4_sat_r <= s3_sat_r;
      s4_inc_r <= s3_inc_r;
      s4_jac_r <= s3_jac_r;

      s5_pl_r  <= s4_mag_r[31:0] * time_step_r;
      s5_ph_r  <= 47'(s4_mag_r[46:32] * time_step_r);
      s5_neg_r <= s4_neg_r;
      s5_sat_r <= s4_sat_r;
      s5_inc_r <= s4_inc_r;
      s5_jac_r <= s4_jac_r;

      s6_p_r   <= p_nxt[78:0];
      s6_neg_r <= s5_neg_r;
      s6_sat_r <= s5_sat_r;
      s6_inc_r <= s5_inc_r;
      s6_jac_r <= s5_jac_r;

      // The quotient reaches 2^33 exactly when the scaled product is at least twice jac.
      dv_r[0].r    <= s6_p_r[64:1];
      dv_r[0].b0   <= s6_p_r[0];
      dv_r[0].jac  <= s6_jac_r;
      dv_r[0].q    <= '0;
      dv_r[0].zero <= (s6_p_r == 79'd0);
      dv_r[0].cap  <= ({1'b0, s6_p_r} >= {15'd0, s6_jac_r, 1'b0});
      dv_r[0].neg  <= s6_neg_r;
      dv_r[0].sat  <= s6_sat_r;
      dv_r[0].inc  <= s6_inc_r;
      for (int k = 1; k <= NS; k++) begin
        dv_r[k] <= dv_nxt[k];
      end

      out_data_r.incr_out  <= 32'(res_c[W-1:0]);
      out_data_r.saturated <= dv_r[NS].sat | res_c[32];
    end
  end

endmodule

@@ verif/advection_y_stencil_point_tb.sv @@
// Self-checking testbench for the y-advection stencil point with a built-in fixed-point predictor.
module advection_y_stencil_point_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 32;
  localparam int LATENCY = 41;
  localparam int CYCLE_LIMIT = 1500000;

  typedef logic signed [127:0] wide_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  advys_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  advys_pkg::out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [31:0]          cfg_data = '0;

  logic [31:0]          dt_now = '0;
  advys_pkg::out_item_t pending_results[$];
  int                   n_errors = 0;
  int                   cycle_count = 0;
  bit                   no_gaps = 1'b0;

  advection_y_stencil_point #(.DATA_WIDTH(DW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wide_t round_half_up(wide_t x, int s);
    return (x + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic wide_t clamp_data(wide_t x, inout bit flag);
    wide_t hi_lim;
    wide_t lo_lim;
    hi_lim = (wide_t'(1) <<< (DW - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (x > hi_lim) begin
      flag = 1'b1;
      return hi_lim;
    end
    if (x < lo_lim) begin
      flag = 1'b1;
      return lo_lim;
    end
    return x;
  endfunction

  function automatic advys_pkg::out_item_t predict_increment(advys_pkg::in_item_t d,
                                                             logic [31:0] dt);
    bit                   sat;
    wide_t                hxl, hxr, va, vb, dm, dp, flux, term, res;
    logic [127:0]         mag, num, jac, quot, cap;
    advys_pkg::out_item_t r;
    sat = 1'b0;
    cap = 128'd1 << 33;
    hxl = wide_t'({96'd0, d.hx_left});
    hxr = wide_t'({96'd0, d.hx_right});
    va = clamp_data(round_half_up(hxl * wide_t'($signed(d.uy_low_left)), 24)
                    + round_half_up(hxr * wide_t'($signed(d.uy_low_right)), 24), sat);
    vb = clamp_data(round_half_up(hxl * wide_t'($signed(d.uy_high_left)), 24)
                    + round_half_up(hxr * wide_t'($signed(d.uy_high_right)), 24), sat);
    dm = clamp_data(wide_t'($signed(d.ux_here)) - wide_t'($signed(d.ux_below)), sat);
    dp = clamp_data(wide_t'($signed(d.ux_above)) - wide_t'($signed(d.ux_here)), sat);
    flux = round_half_up(va * dm, 18) + round_half_up(vb * dp, 18);
    mag = (flux < 0) ? 128'(-flux) : 128'(flux);
    num = (mag * {96'd0, dt}) << 32;
    jac = {96'd0, d.hx_face} * {96'd0, d.hy_center};
    if (num == 0) quot = '0;
    else if (jac == 0) quot = cap;
    else quot = num / jac;
    if (quot > cap) quot = cap;
    term = (flux < 0) ? -wide_t'(quot) : wide_t'(quot);
    res = clamp_data(wide_t'($signed(d.incr_in)) - term, sat);
    r.incr_out = res[31:0];
    r.saturated = sat;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_gaps) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // Record accepted inputs and check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    advys_pkg::out_item_t want;
    if (rst_n && in_valid && !in_stall) pending_results.push_back(predict_increment(in_data, dt_now));
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no input item outstanding: incr_out=%h", out_data.incr_out);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.incr_out !== want.incr_out) begin
          $error("incr_out expected %h actual %h", want.incr_out, out_data.incr_out);
          n_errors++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, out_data.saturated);
          n_errors++;
        end
      end
    end
  end

  // Random backpressure from the result side.
  always @(posedge clk) begin
    if (no_gaps) out_stall <= 1'b0;
    else if ($urandom_range(99) < 3) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(99) < 8) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("advection_y_stencil_point_tb: done, errors");
      $finish;
    end
  end

  task automatic send_item(advys_pkg::in_item_t d);
    int gap;
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The extra edge lets an item accepted at the current edge reach the queue first.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_time_step(logic [31:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dt_now = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic advys_pkg::in_item_t make_item(logic [31:0] hf, hl, hr, hy,
                                                    logic [31:0] a, b, c, e, xb, xh, xa, inc);
    advys_pkg::in_item_t d;
    d.hx_face = hf; d.hx_left = hl; d.hx_right = hr; d.hy_center = hy;
    d.uy_low_left = a; d.uy_low_right = b; d.uy_high_left = c; d.uy_high_right = e;
    d.ux_below = xb; d.ux_here = xh; d.ux_above = xa; d.incr_in = inc;
    return d;
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(9))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom();
      default: return 32'h0100_0000 + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_velocity();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic advys_pkg::in_item_t rand_item();
    return make_item(rand_scale(), rand_scale(), rand_scale(), rand_scale(),
                     rand_velocity(), rand_velocity(), rand_velocity(), rand_velocity(),
                     rand_velocity(), rand_velocity(), rand_velocity(), rand_velocity());
  endfunction

  task automatic test_directed();
    localparam logic [31:0] ONE_S = 32'h0100_0000;
    localparam logic [31:0] ONE_V = 32'h0001_0000;
    localparam logic [31:0] VMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VMIN = 32'h8000_0000;
    // Time step still at its reset value: every scaled term is zero.
    send_item(make_item(ONE_S, ONE_S, ONE_S, ONE_S, ONE_V, ONE_V, ONE_V, ONE_V,
                        0, ONE_V, 32'h0002_0000, 32'h0000_1234));
    write_time_step(32'h0001_0000);
    send_item(make_item(ONE_S, ONE_S, ONE_S, ONE_S, ONE_V, ONE_V, ONE_V, ONE_V,
                        0, ONE_V, 32'h0002_0000, 32'h0000_1234));
    send_item(make_item(ONE_S, ONE_S, ONE_S, ONE_S, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(32'd1, 32'd1, 32'd1, 32'd1, VMIN, VMIN, VMAX, VMAX,
                        VMIN, VMAX, VMIN, 0));
    send_item(make_item('1, '1, '1, '1, VMAX, VMAX, VMAX, VMAX, VMIN, VMAX, VMIN, VMAX));
    send_item(make_item('1, '1, '1, '1, VMIN, VMIN, VMIN, VMIN, VMAX, VMIN, VMAX, VMIN));
    // Rounding of the face products exactly at one half.
    send_item(make_item(ONE_S, 32'd1, 32'd1, ONE_S, 32'h0080_0000, 32'hFF80_0000,
                        32'h0080_0000, 32'h0080_0000, 0, ONE_V, 0, 0));
    // Difference clamps with otherwise small values.
    send_item(make_item(ONE_S, ONE_S, ONE_S, ONE_S, ONE_V, 0, ONE_V, 0,
                        VMIN, VMAX, VMIN, 0));
    // Increment at each output limit, with a scaled term that moves it back into range.
    send_item(make_item(ONE_S, ONE_S, ONE_S, ONE_S, ONE_V, ONE_V, ONE_V, ONE_V,
                        32'h0003_0000, 0, 0, VMIN));
    send_item(make_item(ONE_S, ONE_S, ONE_S, ONE_S, ONE_V, ONE_V, ONE_V, ONE_V,
                        0, 32'h0003_0000, 32'h0006_0000, VMAX));
    // Tiny Jacobian with fluxes that cancel, so the scaled term is zero.
    send_item(make_item(32'd1, ONE_S, ONE_S, 32'd1, ONE_V, ONE_V, ONE_V, ONE_V,
                        0, ONE_V, 0, 0));
    // Zero scale factors: held term with a nonzero flux, zero term without one.
    send_item(make_item(0, ONE_S, ONE_S, ONE_S, ONE_V, ONE_V, ONE_V, ONE_V,
                        0, ONE_V, 32'h0003_0000, 0));
    send_item(make_item(ONE_S, ONE_S, ONE_S, 0, ONE_V, ONE_V, ONE_V, ONE_V,
                        32'hFFFF_0000, 0, 32'hFFFF_0000, 0));
    send_item(make_item(0, ONE_S, ONE_S, 0, 0, 0, 0, 0, ONE_V, 0, VMAX, 32'h0000_0042));
    write_time_step(32'hFFFF_FFFF);
    send_item(make_item(ONE_S, ONE_S, ONE_S, ONE_S, 32'h0000_0100, 32'h0000_0100,
                        32'hFFFF_FF00, 0, 0, 32'h0000_0010, 32'h0000_0030, 0));
    send_item(make_item('1, '1, '1, '1, ONE_V, VMIN, ONE_V, ONE_V, 0, ONE_V, 0, 32'hAAAA_5555));
    write_time_step(32'd1);
    send_item(make_item(ONE_S, ONE_S, ONE_S, ONE_S, VMAX, VMAX, VMAX, VMAX,
                        VMIN, VMAX, VMIN, 32'h5555_AAAA));
  endtask

  task automatic test_random_stream(int count, logic [31:0] dt);
    write_time_step(dt);
    for (int i = 0; i < count; i++) begin
      send_item(rand_item());
      // Hold the sender once until the pipeline has emptied.
      if (i == count / 2) drain_results();
    end
  endtask

  task automatic test_back_to_back(int count);
    no_gaps = 1'b1;
    for (int i = 0; i < count; i++) send_item(rand_item());
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_stream(500, 32'h0001_0000);
    test_random_stream(300, 32'hFFFF_FFFF);
    test_random_stream(200, 32'h0000_0000);
    test_random_stream(500, $urandom());
    test_back_to_back(200);
    test_random_stream(300, $urandom_range(0, 32'h0004_0000));
    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0) begin
      $display("advection_y_stencil_point_tb: done, clean");
    end else begin
      $display("advection_y_stencil_point_tb: done, errors");
    end
    $finish;
  end

endmodule
